FILE: rtl/core/lsfe_pkg.sv
`timescale 1ns / 1ps

package lsfe_pkg;

	localparam logic [2:0] MODE_CMD  = 3'd0;
	localparam logic [2:0] MODE_DATA = 3'd1;
	localparam logic [2:0] MODE_TEXT = 3'd2;
	localparam logic [2:0] MODE_GFX  = 3'd3;
	localparam logic [2:0] MODE_BNUM = 3'd4;
	localparam logic [2:0] MODE_WNUM = 3'd5;

	localparam logic [7:0] SYNC_CMD   = 8'hF8;
	localparam logic [7:0] SYNC_DATA  = 8'hFA;
	localparam logic [7:0] DIGIT_ZERO = 8'h30;
	localparam logic [7:0] GFX_BASE   = 8'h80;

	// floor(x / 10) == (x * RECIP_10) >> 35 for every 32-bit x
	localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;

	localparam int NUM_DIGITS  = 10;
	localparam int BNUM_DIGITS = 3;
	localparam int CNT_W       = 4;
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic       is_data;
		logic [7:0] value;
		logic       last;
	} entry_t;

	function automatic logic [7:0] text_row_base(input logic [1:0] r);
		logic [7:0] b;
		case (r)
			2'd0: b = 8'h80;
			2'd1: b = 8'h90;
			2'd2: b = 8'h88;
			default: b = 8'h98;
		endcase
		return b;
	endfunction

endpackage

FILE: rtl/core/lcd_serial_frame_encoder.sv
`timescale 1ns / 1ps

// channel   handshake           payload
// request   push / full         mode, byte_value, number, row, column, pixel_word
// bytes     empty / pop         spi_byte, last_byte
//
// an item yields 3 (command, data, text cursor), 12 (graphic word), 9 (byte number)
// or 30 (word number) bytes, one per cycle while pop is held; codes 6 and 7 yield none
// the front takes no new item until it has passed every entry of the last one to the queue;
// number modes pass each decimal digit through the F_MUL and F_DIG states, using the
// shared divide-by-ten multiplier in turn for every digit
// a stall on pop fills the entry queue and holds the front, so full stays high; reset clears all control

module lcd_serial_frame_encoder import lsfe_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  mode,
	input  logic [7:0]  byte_value,
	input  logic [31:0] number,
	input  logic [4:0]  row,
	input  logic [2:0]  column,
	input  logic [15:0] pixel_word,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  spi_byte,
	output logic        last_byte
);

	entry_t f_data;
	logic   f_push;
	logic   f_full;
	entry_t b_data;
	logic   b_empty;
	logic   b_pop;

	lsfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.mode       (mode),
		.byte_value (byte_value),
		.number     (number),
		.row        (row),
		.column     (column),
		.pixel_word (pixel_word),
		.ent_push   (f_push),
		.ent_data   (f_data),
		.ent_full   (f_full)
	);

	lsfe_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (f_push),
		.wr_data (f_data),
		.full    (f_full),
		.pop     (b_pop),
		.rd_data (b_data),
		.empty   (b_empty)
	);

	lsfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_data    (b_data),
		.q_empty   (b_empty),
		.q_pop     (b_pop),
		.spi_byte  (spi_byte),
		.last_byte (last_byte),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

FILE: rtl/core/lsfe_front.sv
`timescale 1ns / 1ps

module lsfe_front import lsfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  mode,
	input  logic [7:0]  byte_value,
	input  logic [31:0] number,
	input  logic [4:0]  row,
	input  logic [2:0]  column,
	input  logic [15:0] pixel_word,
	output logic        ent_push,
	output entry_t      ent_data,
	input  logic        ent_full
);

	typedef enum logic [1:0] {F_IDLE, F_MUL, F_DIG, F_EMIT} fstate_t;

	fstate_t            state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [2:0]         mode_q;
	logic [7:0]         byte_q;
	logic [4:0]         row_q;
	logic [2:0]         col_q;
	logic [15:0]        pix_q;
	logic [31:0]        x_q;
	logic [63:0]        prod_q;
	logic [3:0]         digits_q [NUM_DIGITS];

	logic               accept;
	logic [28:0]        quot;
	logic [31:0]        quot10;
	logic [31:0]        rem;
	logic [CNT_W-1:0]   last_digit;

	assign full     = (state_q != F_IDLE);
	assign accept   = push && !full;
	assign ent_push = (state_q == F_EMIT) && !ent_full;

	assign quot   = prod_q[63:35];
	assign quot10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
	assign rem    = x_q - quot10;
	assign last_digit = (mode_q == MODE_WNUM) ? CNT_W'(NUM_DIGITS - 1) : CNT_W'(BNUM_DIGITS - 1);

	always_comb begin
		ent_data      = '0;
		ent_data.last = (cnt_q == '0);
		unique case (mode_q) inside
			MODE_CMD: begin
				ent_data.value = byte_q;
			end
			MODE_DATA: begin
				ent_data.is_data = 1'b1;
				ent_data.value   = byte_q;
			end
			MODE_TEXT: begin
				ent_data.value = text_row_base(row_q[1:0]) | {5'b00000, col_q};
			end
			MODE_GFX: begin
				unique case (cnt_q[1:0])
					2'd3: ent_data.value = GFX_BASE | {3'b000, row_q};
					2'd2: ent_data.value = GFX_BASE | {5'b00000, col_q};
					2'd1: begin
						ent_data.is_data = 1'b1;
						ent_data.value   = pix_q[15:8];
					end
					default: begin
						ent_data.is_data = 1'b1;
						ent_data.value   = pix_q[7:0];
					end
				endcase
			end
			MODE_BNUM, MODE_WNUM: begin
				ent_data.is_data = 1'b1;
				ent_data.value   = DIGIT_ZERO | {4'b0000, digits_q[cnt_q]};
			end
			default: begin
				ent_data.value = byte_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == F_DIG) begin
			digits_q[cnt_q] <= rem[3:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
			mode_q  <= MODE_CMD;
			byte_q  <= '0;
			row_q   <= '0;
			col_q   <= '0;
			pix_q   <= '0;
			x_q     <= '0;
			prod_q  <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						mode_q <= mode;
						byte_q <= byte_value;
						row_q  <= row;
						col_q  <= column;
						pix_q  <= pixel_word;
						unique case (mode) inside
							MODE_CMD, MODE_DATA, MODE_TEXT: begin
								cnt_q   <= '0;
								state_q <= F_EMIT;
							end
							MODE_GFX: begin
								cnt_q   <= CNT_W'(3);
								state_q <= F_EMIT;
							end
							MODE_BNUM: begin
								cnt_q   <= '0;
								x_q     <= {24'h000000, number[7:0]};
								state_q <= F_MUL;
							end
							MODE_WNUM: begin
								cnt_q   <= '0;
								x_q     <= number;
								state_q <= F_MUL;
							end
							default: state_q <= F_IDLE;
						endcase
					end
				end
				F_MUL: begin
					prod_q  <= 64'(x_q) * 64'(RECIP_10);
					state_q <= F_DIG;
				end
				F_DIG: begin
					x_q <= {3'b000, quot};
					if (cnt_q == last_digit) begin
						state_q <= F_EMIT;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= F_MUL;
					end
				end
				F_EMIT: begin
					if (ent_push) begin
						if (cnt_q == '0) begin
							state_q <= F_IDLE;
						end else begin
							cnt_q <= cnt_q - 1'b1;
						end
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/core/lsfe_queue.sv
`timescale 1ns / 1ps

module lsfe_queue import lsfe_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wr_data,
	output logic   full,
	input  logic   pop,
	output entry_t rd_data,
	output logic   empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t          slots_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/lsfe_back.sv
`timescale 1ns / 1ps

module lsfe_back import lsfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  entry_t     q_data,
	input  logic       q_empty,
	output logic       q_pop,
	output logic [7:0] spi_byte,
	output logic       last_byte,
	output logic       empty,
	input  logic       pop
);

	typedef enum logic [1:0] {PH_SYNC, PH_HIGH, PH_LOW} phase_t;

	phase_t     phase_q;
	logic       busy_q;
	entry_t     ent_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       last_q;

	logic       advance;
	logic [7:0] cur_byte;

	assign advance = !out_valid_q || pop;
	assign q_pop   = !q_empty && (!busy_q || (advance && phase_q == PH_LOW));

	always_comb begin
		unique case (phase_q)
			PH_SYNC: cur_byte = ent_q.is_data ? SYNC_DATA : SYNC_CMD;
			PH_HIGH: cur_byte = {ent_q.value[7:4], 4'b0000};
			default: cur_byte = {ent_q.value[3:0], 4'b0000};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SYNC;
			busy_q      <= 1'b0;
			ent_q       <= '0;
			out_valid_q <= 1'b0;
			byte_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= busy_q;
				if (busy_q) begin
					byte_q <= cur_byte;
					last_q <= ent_q.last && (phase_q == PH_LOW);
				end
			end
			if (q_pop) begin
				ent_q   <= q_data;
				phase_q <= PH_SYNC;
				busy_q  <= 1'b1;
			end else if (advance && busy_q) begin
				unique case (phase_q)
					PH_SYNC: phase_q <= PH_HIGH;
					PH_HIGH: phase_q <= PH_LOW;
					default: begin
						phase_q <= PH_SYNC;
						busy_q  <= 1'b0;
					end
				endcase
			end
		end
	end

	assign spi_byte  = byte_q;
	assign last_byte = last_q;
	assign empty     = !out_valid_q;

endmodule

FILE: rtl/core/lsfe_checker.sv
`timescale 1ns / 1ps

module lsfe_checker import lsfe_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [7:0] spi_byte,
	input logic       last_byte
);

	// high while the next item out starts a new frame
	logic first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (pop && !empty) begin
			first_q <= last_byte;
		end
	end

	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> empty && !full)
		else $error("outputs not quiet in reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(spi_byte) && $stable(last_byte))
		else $error("waiting item changed");

	a_frame_sync: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && first_q |-> spi_byte == SYNC_CMD || spi_byte == SYNC_DATA)
		else $error("frame does not open with a sync byte");

	a_sync_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && first_q |-> !last_byte)
		else $error("sync byte flagged as last");

	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !$isunknown({spi_byte, last_byte, full}))
		else $error("unknown value on a waiting item");

endmodule

bind lcd_serial_frame_encoder lsfe_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.push      (push),
	.full      (full),
	.empty     (empty),
	.pop       (pop),
	.spi_byte  (spi_byte),
	.last_byte (last_byte)
);
